@@ sv/tcw_pkg.sv @@
package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int PTR_W   = $clog2(CELLS + 1);

  // Field widths.
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFS_W  = 12;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam logic [CFG_ADDR_W-1:0] REG_TEXT_ATTR = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCROLL_EN = 1'b1;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] CLEAR_ATTR = 8'h0F;
  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

endpackage

@@ sv/text_console_writer_top.sv @@
// Text console writer: an 80x25 store of 16-bit cells (attribute high byte,
// character low byte) and a cursor.
// The input stream carries one command per transaction: in_tuser holds the
// operation (put character, set cursor, clear, read cell) and in_tdata the
// character and position. Every command yields exactly one result
// transaction with the cursor, its linear offset and, for a read, the cell.
// The configuration port writes the text attribute (index 0) and the scroll
// enable (index 1); write it only while no command is in flight.
// A put that scrolls moves or blanks every cell once through the single
// write port. in_tready is high only while the sequencer is idle; one
// command is in work at a time, so the next one is taken only once the
// result of the last one has been loaded into the output register.
// After reset, a clearing pass writes 0x0F20 to all 2000 cells, one per
// cycle, and in_tready stays low throughout; configuration writes are
// taken during that pass.
// The result sits in an output register: while the receiver stalls, a new
// command is still accepted, but its result waits until the register drains.
module text_console_writer_top
  import tcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // char_code, pos_x, pos_y, zero pad
  input  logic [OP_W-1:0]       in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // cursor_col, cursor_row, cursor_offset, cell_data
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [6:0] {
    S_FILL      = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_EXEC      = 7'b0000100,
    S_SCR_SETUP = 7'b0001000,
    S_COPY      = 7'b0010000,
    S_RDWAIT    = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [COL_W-1:0]  cursor_x_r, cursor_x_nxt;
  logic [ROW_W-1:0]  cursor_y_r, cursor_y_nxt;
  logic [ATTR_W-1:0] attr_r;
  logic              scroll_en_r;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic              pend_r, pend_nxt;
  logic              fill_to_idle_r, fill_to_idle_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers.
  op_t               op_r;
  logic [CHAR_W-1:0] ch_r;
  logic [COL_W-1:0]  px_r;
  logic [ROW_W-1:0]  py_r;
  logic [CELL_W-1:0] cell_r, cell_nxt;
  logic [CELL_W-1:0] fill_val_r, fill_val_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Cell store.
  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] mem_rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  // Shared address unit: row * COLUMNS + col.
  logic [ROW_W-1:0] au_row;
  logic [COL_W-1:0] au_col;
  logic [OFS_W-1:0] au_res;

  logic              in_accept;
  logic              out_load;
  logic [COL_W:0]    x_t;
  logic [ROW_W-1:0]  y_t;
  logic              printable;
  logic              issue;
  logic [ROW_W-1:0]  shift;

  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);

  assign shift     = cursor_y_r - ROW_W'(ROWS - 1);
  assign printable = (ch_r >= CH_SPACE);
  assign issue     = (rd_ptr_r < PTR_W'(CELLS));

  always_comb begin
    unique case (state_r)
      S_EXEC: begin
        if (op_r == OP_READ) begin
          au_row = py_r;
          au_col = px_r;
        end else begin
          au_row = cursor_y_r;
          au_col = cursor_x_r;
        end
      end
      S_SCR_SETUP: begin
        au_row = shift;
        au_col = '0;
      end
      default: begin
        au_row = cursor_y_r;
        au_col = cursor_x_r;
      end
    endcase
  end

  assign au_res = OFS_W'(au_row) * OFS_W'(COLUMNS) + OFS_W'(au_col);

  // Cursor update for a put: control codes, then wrap at the right edge.
  always_comb begin
    x_t = {1'b0, cursor_x_r};
    y_t = cursor_y_r;
    case (ch_r)
      CH_BS: begin
        if (cursor_x_r != '0) x_t = x_t - 1'b1;
      end
      CH_TAB: begin
        x_t = (x_t + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
      end
      CH_CR: begin
        x_t = '0;
      end
      CH_LF: begin
        x_t = '0;
        if (scroll_en_r || cursor_y_r < ROW_W'(ROWS)) y_t = y_t + 1'b1;
      end
      default: begin
        if (printable) x_t = x_t + 1'b1;
      end
    endcase
    if (x_t >= (COL_W+1)'(COLUMNS)) begin
      x_t = '0;
      if (scroll_en_r || y_t < ROW_W'(ROWS)) y_t = y_t + 1'b1;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cursor_x_nxt     = cursor_x_r;
    cursor_y_nxt     = cursor_y_r;
    wr_ptr_nxt       = wr_ptr_r;
    rd_ptr_nxt       = rd_ptr_r;
    pend_nxt         = 1'b0;
    fill_to_idle_nxt = fill_to_idle_r;
    fill_val_nxt     = fill_val_r;
    cell_nxt         = cell_r;
    out_valid_nxt    = out_valid_r;
    mem_we           = 1'b0;
    mem_waddr        = wr_ptr_r[ADDR_W-1:0];
    mem_wdata        = fill_val_r;
    mem_raddr        = rd_ptr_r[ADDR_W-1:0];

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_FILL: begin
        mem_we     = 1'b1;
        wr_ptr_nxt = wr_ptr_r + 1'b1;
        if (wr_ptr_r == PTR_W'(CELLS - 1)) begin
          state_nxt = fill_to_idle_r ? S_IDLE : S_DONE;
        end
      end
      S_IDLE: begin
        cell_nxt = '0;
        if (in_accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        unique case (op_r)
          OP_PUT: begin
            if (printable && cursor_y_r < ROW_W'(ROWS)) begin
              mem_we    = 1'b1;
              mem_waddr = au_res[ADDR_W-1:0];
              mem_wdata = {attr_r, ch_r};
            end
            cursor_x_nxt = x_t[COL_W-1:0];
            cursor_y_nxt = y_t;
            state_nxt = (scroll_en_r && y_t >= ROW_W'(ROWS)) ? S_SCR_SETUP : S_DONE;
          end
          OP_SET: begin
            cursor_x_nxt = (px_r < COL_W'(COLUMNS)) ? px_r : COL_W'(COLUMNS - 1);
            cursor_y_nxt = (py_r < ROW_W'(ROWS)) ? py_r : ROW_W'(ROWS - 1);
            state_nxt = S_DONE;
          end
          OP_CLEAR: begin
            cursor_x_nxt     = '0;
            cursor_y_nxt     = '0;
            wr_ptr_nxt       = '0;
            fill_val_nxt     = {CLEAR_ATTR, ch_r};
            fill_to_idle_nxt = 1'b0;
            state_nxt        = S_FILL;
          end
          default: begin
            mem_raddr = au_res[ADDR_W-1:0];
            if (px_r < COL_W'(COLUMNS) && py_r < ROW_W'(ROWS)) begin
              state_nxt = S_RDWAIT;
            end else begin
              state_nxt = S_DONE;
            end
          end
        endcase
      end
      S_SCR_SETUP: begin
        // Move the store up by the rows the cursor has passed.
        wr_ptr_nxt   = '0;
        rd_ptr_nxt   = (shift >= ROW_W'(ROWS)) ? PTR_W'(CELLS) : au_res[PTR_W-1:0];
        cursor_y_nxt = ROW_W'(ROWS - 1);
        state_nxt    = S_COPY;
      end
      S_COPY: begin
        // Each read feeds the write in the cycle after it is issued.
        if (issue) rd_ptr_nxt = rd_ptr_r + 1'b1;
        pend_nxt = issue;
        if (pend_r) begin
          mem_we     = 1'b1;
          mem_wdata  = mem_rdata_r;
          wr_ptr_nxt = wr_ptr_r + 1'b1;
        end
        if (!issue && !pend_r) begin
          fill_val_nxt     = {attr_r, CH_SPACE};
          fill_to_idle_nxt = 1'b0;
          state_nxt        = S_FILL;
        end
      end
      S_RDWAIT: begin
        cell_nxt  = mem_rdata_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_FILL;
      cursor_x_r     <= '0;
      cursor_y_r     <= '0;
      attr_r         <= RESET_ATTR;
      scroll_en_r    <= 1'b1;
      wr_ptr_r       <= '0;
      rd_ptr_r       <= '0;
      pend_r         <= 1'b0;
      fill_to_idle_r <= 1'b1;
      fill_val_r     <= {CLEAR_ATTR, CH_SPACE};
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cursor_x_r     <= cursor_x_nxt;
      cursor_y_r     <= cursor_y_nxt;
      wr_ptr_r       <= wr_ptr_nxt;
      rd_ptr_r       <= rd_ptr_nxt;
      pend_r         <= pend_nxt;
      fill_to_idle_r <= fill_to_idle_nxt;
      fill_val_r     <= fill_val_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_TEXT_ATTR: attr_r      <= cfg_wdata[ATTR_W-1:0];
          REG_SCROLL_EN: scroll_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r <= op_t'(in_tuser);
      ch_r <= in_tdata[CHAR_W-1:0];
      px_r <= in_tdata[CHAR_W+COL_W-1:CHAR_W];
      py_r <= in_tdata[CHAR_W+COL_W+ROW_W-1:CHAR_W+COL_W];
    end
    cell_r <= cell_nxt;
    if (out_load) begin
      out_data_r <= {cell_r, au_res, cursor_y_r, cursor_x_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_x_r < COL_W'(COLUMNS))
    else $error("cursor column out of range");

  a_row_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> cursor_y_r <= ROW_W'(ROWS))
    else $error("cursor row beyond saturation while idle");

  a_copy_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COPY |-> rd_ptr_r >= wr_ptr_r)
    else $error("scroll copy read fell behind write");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL |-> wr_ptr_r < PTR_W'(CELLS))
    else $error("fill pass beyond the store");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_EXEC)
    else $error("accepted transaction did not start execution");
`endif

endmodule
